// ===== hw/rtl/dttf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text parser package
// Shared types, character codes and the decimal scale table used by the
// parser front end, the job queue and the value-forming back end.
// ----------------------------------------------------------------------------
package dttf_pkg;

    // Fraction digits kept and the longest text taken before a forced end.
    localparam int FRAC_DIGITS = 9;
    localparam int MAX_TEXT    = 65535;

    // Quotient bits of the fraction scaling (Q.16 fraction).
    localparam int QUO_BITS = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_number;
    } t_in_item;

    typedef struct packed {
        logic signed [48:0] fixed_value;
        logic [15:0]        end_offset;
        logic               overflow;
    } t_out_item;

    // One finished parse, waiting for value formation.
    typedef struct packed {
        logic        negative;
        logic [31:0] integer_accum;
        logic [29:0] fraction_accum;
        logic [3:0]  fraction_count;
        logic [15:0] byte_offset;
        logic        saturated;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_INT,
        PH_FRAC
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIN
    } t_back_state;

    // Ten to the power of the fraction digit count.
    function automatic logic [29:0] dec_scale(input logic [3:0] cnt);
        logic [29:0] s;
        case (cnt)
            4'd0:    s = 30'd1;
            4'd1:    s = 30'd10;
            4'd2:    s = 30'd100;
            4'd3:    s = 30'd1000;
            4'd4:    s = 30'd10000;
            4'd5:    s = 30'd100000;
            4'd6:    s = 30'd1000000;
            4'd7:    s = 30'd10000000;
            4'd8:    s = 30'd100000000;
            4'd9:    s = 30'd1000000000;
            default: s = 30'd1;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/dttf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser front end
// Takes one text byte per transfer, runs the lead/integer/fraction phases and
// pushes a finished parse into the job queue on the terminating byte.
// ----------------------------------------------------------------------------
module dttf_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  dttf_pkg::t_in_item      i_in_data,
    input  dttf_pkg::t_queue_status i_q_status,
    output logic                    o_push,
    output dttf_pkg::t_job          o_job
);

    dttf_pkg::t_phase r_phase, n_phase, c_phase;
    logic        r_neg, n_neg, c_neg;
    logic [31:0] r_int, n_int, c_int;
    logic [29:0] r_frac, n_frac, c_frac;
    logic [3:0]  r_fcnt, n_fcnt, c_fcnt;
    logic [15:0] r_off, n_off, c_off;
    logic        r_sat, n_sat, c_sat;

    logic        accept;
    logic        advance;
    logic        is_space;
    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] int_next;
    logic [29:0] frac_next;
    logic [7:0]  b;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign b          = i_in_data.text_byte;

    assign is_space = (b == dttf_pkg::CH_SPACE) || (b == dttf_pkg::CH_TAB) ||
                      (b == dttf_pkg::CH_CR) || (b == dttf_pkg::CH_LF);
    assign is_digit = (b >= dttf_pkg::CH_ZERO) && (b <= dttf_pkg::CH_NINE);
    assign digit    = 4'(b - dttf_pkg::CH_ZERO);

    always_comb begin
        // A start byte discards any parse in flight before it is looked at.
        if (i_in_data.start_number) begin
            c_phase = dttf_pkg::PH_LEAD;
            c_neg   = 1'b0;
            c_int   = '0;
            c_frac  = '0;
            c_fcnt  = '0;
            c_off   = '0;
            c_sat   = 1'b0;
        end else begin
            c_phase = r_phase;
            c_neg   = r_neg;
            c_int   = r_int;
            c_frac  = r_frac;
            c_fcnt  = r_fcnt;
            c_off   = r_off;
            c_sat   = r_sat;
        end
    end

    // Times ten as two shifts and an add.
    assign int_next  = ({4'b0, c_int} << 3) + ({4'b0, c_int} << 1) + 36'(digit);
    assign frac_next = (c_frac << 3) + (c_frac << 1) + 30'(digit);

    assign o_job = '{negative:       c_neg,
                     integer_accum:  c_int,
                     fraction_accum: c_frac,
                     fraction_count: c_fcnt,
                     byte_offset:    c_off,
                     saturated:      c_sat};

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_int   = r_int;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        n_off   = r_off;
        n_sat   = r_sat;
        o_push  = 1'b0;
        advance = 1'b0;
        if (accept) begin
            n_phase = c_phase;
            n_neg   = c_neg;
            n_int   = c_int;
            n_frac  = c_frac;
            n_fcnt  = c_fcnt;
            n_off   = c_off;
            n_sat   = c_sat;
            if (c_phase != dttf_pkg::PH_IDLE) begin
                if (c_off >= 16'(dttf_pkg::MAX_TEXT)) begin
                    o_push  = 1'b1;
                    n_phase = dttf_pkg::PH_IDLE;
                end else begin
                    case (c_phase)
                        dttf_pkg::PH_LEAD: begin
                            if (is_space) begin
                                advance = 1'b1;
                            end else if (b == dttf_pkg::CH_MINUS) begin
                                n_neg   = 1'b1;
                                n_phase = dttf_pkg::PH_INT;
                                advance = 1'b1;
                            end else if (b == dttf_pkg::CH_PLUS) begin
                                n_phase = dttf_pkg::PH_INT;
                                advance = 1'b1;
                            end else if (is_digit) begin
                                if (int_next[35:32] != 4'd0) begin
                                    n_int = '1;
                                    n_sat = 1'b1;
                                end else begin
                                    n_int = int_next[31:0];
                                end
                                n_phase = dttf_pkg::PH_INT;
                                advance = 1'b1;
                            end else if (b == dttf_pkg::CH_DOT) begin
                                n_phase = dttf_pkg::PH_FRAC;
                                advance = 1'b1;
                            end else begin
                                o_push  = 1'b1;
                                n_phase = dttf_pkg::PH_IDLE;
                            end
                        end
                        dttf_pkg::PH_INT: begin
                            if (is_digit) begin
                                if (int_next[35:32] != 4'd0) begin
                                    n_int = '1;
                                    n_sat = 1'b1;
                                end else begin
                                    n_int = int_next[31:0];
                                end
                                advance = 1'b1;
                            end else if (b == dttf_pkg::CH_DOT) begin
                                n_phase = dttf_pkg::PH_FRAC;
                                advance = 1'b1;
                            end else begin
                                o_push  = 1'b1;
                                n_phase = dttf_pkg::PH_IDLE;
                            end
                        end
                        dttf_pkg::PH_FRAC: begin
                            if (is_digit) begin
                                // Digits past the kept precision are consumed only.
                                if (c_fcnt < 4'(dttf_pkg::FRAC_DIGITS)) begin
                                    n_frac = frac_next;
                                    n_fcnt = c_fcnt + 4'd1;
                                end
                                advance = 1'b1;
                            end else begin
                                o_push  = 1'b1;
                                n_phase = dttf_pkg::PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = dttf_pkg::PH_IDLE;
                        end
                    endcase
                    if (advance) begin
                        n_off = c_off + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dttf_pkg::PH_IDLE;
            r_neg   <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_fcnt  <= '0;
            r_off   <= '0;
            r_sat   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            r_off   <= n_off;
            r_sat   <= n_sat;
        end
    end

`ifndef ASSERT_OFF
    a_fcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= 4'(dttf_pkg::FRAC_DIGITS))
        else $error("fraction digit count above kept precision");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_status.full |-> !o_push)
        else $error("parse finished while the job queue was full");
`endif

endmodule

// ===== hw/rtl/dttf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out queue of finished parses between the front end
// and the back end.
// ----------------------------------------------------------------------------
module dttf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  dttf_pkg::t_job          i_job,
    input  logic                    i_pop,
    output dttf_pkg::t_job          o_job,
    output dttf_pkg::t_queue_status o_status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dttf_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("pop from an empty job queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("job queue count beyond depth");
`endif

endmodule

// ===== hw/rtl/dttf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value forming back end
// Scales the decimal fraction to 16 binary bits with a restoring divider,
// joins it to the integer part, applies the sign and holds the result.
// ----------------------------------------------------------------------------
module dttf_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dttf_pkg::t_queue_status i_q_status,
    input  dttf_pkg::t_job          i_job,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output dttf_pkg::t_out_item     o_out_data
);

    localparam int SW = $clog2(dttf_pkg::QUO_BITS);

    dttf_pkg::t_back_state r_state, n_state;

    logic [SW-1:0] r_step;
    logic [29:0]   r_rem, r_div;
    logic [15:0]   r_quo;
    logic          r_neg;
    logic [31:0]   r_int;
    logic [15:0]   r_off;
    logic          r_sat;

    logic                r_out_valid;
    dttf_pkg::t_out_item r_out;

    logic        out_free;
    logic        load_out;
    logic [30:0] rem2;
    logic        ge;
    logic [48:0] mag;

    assign out_free = !r_out_valid || !i_out_stall;
    assign rem2     = {r_rem, 1'b0};
    assign ge       = rem2 >= {1'b0, r_div};
    assign mag      = {1'b0, r_int, r_quo};

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            dttf_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = dttf_pkg::BK_DIV;
                end
            end
            dttf_pkg::BK_DIV: begin
                if (r_step == SW'(dttf_pkg::QUO_BITS - 1)) begin
                    n_state = dttf_pkg::BK_FIN;
                end
            end
            dttf_pkg::BK_FIN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = dttf_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = dttf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dttf_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider datapath: the fraction is below the divisor, so every
    // remainder stays below it and the quotient fits in 16 bits.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem  <= i_job.fraction_accum;
            r_div  <= dttf_pkg::dec_scale(i_job.fraction_count);
            r_quo  <= '0;
            r_step <= '0;
            r_neg  <= i_job.negative;
            r_int  <= i_job.integer_accum;
            r_off  <= i_job.byte_offset;
            r_sat  <= i_job.saturated;
        end else if (r_state == dttf_pkg::BK_DIV) begin
            r_rem  <= ge ? 30'(rem2 - {1'b0, r_div}) : rem2[29:0];
            r_quo  <= {r_quo[14:0], ge};
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.fixed_value <= r_neg ? $signed(49'(0) - mag) : $signed(mag);
            r_out.end_offset  <= r_off;
            r_out.overflow    <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dttf_pkg::BK_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dttf_pkg::BK_FIN && !out_free) |=> (r_state == dttf_pkg::BK_FIN))
        else $error("finished value dropped while output busy");
`endif

endmodule

// ===== hw/rtl/decimal_text_to_fixed_parser.sv =====
`timescale 1ns / 1ps
// Throughput: one text byte per cycle while the job queue has room; results
// leave one at a time: a pop, the 16-bit fraction division, then a load.
// Reset: synchronous, active low; clears the parse, the queue and the output,
// after which no parse is active until a byte with start_number arrives.
// ----------------------------------------------------------------------------
// Decimal text to fixed-point parser
// Streams ASCII text one byte per transfer and returns one signed Q32.16
// value, consumed byte count and overflow flag per parsed number.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dttf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dttf_pkg::t_out_item o_out_data
);

    // The front end walks the text and accumulates the integer part,
    // the fraction digits as a decimal integer, the sign and the byte
    // count. It stalls its input only when the job queue is full, so a
    // terminating byte always finds room for its finished parse.
    dttf_pkg::t_queue_status q_status;
    dttf_pkg::t_job          push_job;
    dttf_pkg::t_job          head_job;
    logic                    push;
    logic                    pop;

    dttf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    // The queue lets the byte stream run on while earlier numbers are
    // still being scaled and while a finished result waits downstream.
    dttf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // The back end turns the decimal fraction into 16 binary fraction bits
    // by division with one quotient bit per cycle, then applies the sign
    // and places the value in an output register that parts it from the
    // consumer.
    dttf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
